FILE: rtl/laplacian_subtract_clamp_3x3_core_defines.svh
// assertion macros for the checker file
`ifndef LAPLACIAN_SUBTRACT_CLAMP_3X3_CORE_DEFINES_SVH
`define LAPLACIAN_SUBTRACT_CLAMP_3X3_CORE_DEFINES_SVH

// clocked assertion, off while reset is low
`define LSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define LSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lsc_pkg.sv
`default_nettype none

package lsc_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 11;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef logic [PIX_W-1:0] t_pix;

    // one window column, top row is the oldest line
    typedef struct packed {
        t_pix bot;
        t_pix mid;
        t_pix top;
    } t_col;

    // which neighbours of the centre lie inside the image
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_nbr_mask;

endpackage

`default_nettype wire

FILE: rtl/lsc_line_mem.sv
`default_nettype none

module lsc_line_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/lsc_col_cell.sv
`default_nettype none

module lsc_col_cell (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_shift,
    input  wire lsc_pkg::t_col i_col,
    output lsc_pkg::t_col     o_col
);

    lsc_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

FILE: rtl/lsc_sharpen.sv
`default_nettype none

module lsc_sharpen (
    input  wire lsc_pkg::t_col      i_left,
    input  wire lsc_pkg::t_col      i_centre,
    input  wire lsc_pkg::t_col      i_right,
    input  wire lsc_pkg::t_nbr_mask i_mask,
    output lsc_pkg::t_pix           o_pix
);

    logic [9:0]         nbr_sum;
    logic [9:0]         centre_x3;
    logic signed [11:0] diff;

    // centre - (4*centre - sum) folds to sum - 3*centre
    always_comb begin
        nbr_sum = (i_mask.up    ? 10'(i_centre.top) : 10'd0)
                + (i_mask.down  ? 10'(i_centre.bot) : 10'd0)
                + (i_mask.left  ? 10'(i_left.mid)   : 10'd0)
                + (i_mask.right ? 10'(i_right.mid)  : 10'd0);
        centre_x3 = 10'(i_centre.mid) + {1'b0, i_centre.mid, 1'b0};
        diff = $signed({2'b00, nbr_sum}) - $signed({2'b00, centre_x3});
        if (diff < 0) begin
            o_pix = '0;
        end else if (diff > $signed(12'(lsc_pkg::PIX_MAX))) begin
            o_pix = lsc_pkg::PIX_MAX;
        end else begin
            o_pix = diff[lsc_pkg::PIX_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/laplacian_subtract_clamp_3x3_core.sv
// a result reaches the output through the line store read, the window shift and the
//   output register after the request that completes its neighbourhood is accepted
// throughput: one request per clock, stalls only when the output register is held
// reset: synchronous, active low; image size 256 or MAX_SIZE if less, counters and
//   window cleared, line stores keep their contents and need no clearing pass
`default_nettype none

module laplacian_subtract_clamp_3x3_core #(
    parameter int MAX_SIZE = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input stream
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [7:0]                i_s_tdata,   // [7:0] pixel_in
    input  wire logic                      i_s_tuser,   // [0] op: 0 pixel, 1 drain
    // output stream
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [7:0]                     o_m_tdata,   // [7:0] pixel_out
    output logic                           o_m_tlast,   // frame_last
    // image size register
    input  wire logic                      i_cfg_we,
    input  wire logic [lsc_pkg::CFG_W-1:0] i_cfg_wdata
);

    // column address width and width of side / row values (row runs to side + 1)
    localparam int AW = $clog2(MAX_SIZE);
    localparam int NW = $clog2(MAX_SIZE + 2);
    localparam int RESET_SIDE = (MAX_SIZE < 256) ? MAX_SIZE : 256;
    localparam logic [NW-1:0] SIDE_MIN = NW'(3);
    localparam logic [NW-1:0] SIDE_MAX = NW'(MAX_SIZE);
    localparam int MW = 2 * lsc_pkg::PIX_W;

    // clamped image side and raster position of the next request
    logic [NW-1:0] r_side;
    logic [AW-1:0] r_col;
    logic [NW-1:0] r_row;
    logic [NW-1:0] n_side;
    logic [AW-1:0] n_col;
    logic [NW-1:0] n_row;
    logic [31:0]   cfg_ext;

    // handshake chain
    logic out_free;
    logic s2_go;
    logic s2_rdy;
    logic s1_go;
    logic s1_rdy;
    logic accept;

    // position decode of the incoming request
    logic [NW-1:0]      col_ext;
    logic [NW-1:0]      col_inc;
    logic [NW-1:0]      row_prev;
    logic               in_emit;
    logic               in_last;
    lsc_pkg::t_nbr_mask in_mask;
    lsc_pkg::t_pix      in_pix;

    // stage 1: line store read in flight
    logic               r_s1_valid;
    logic [AW-1:0]      r_s1_addr;
    lsc_pkg::t_pix      r_s1_pix;
    logic               r_s1_emit;
    logic               r_s1_last;
    lsc_pkg::t_nbr_mask r_s1_mask;
    logic               r_fwd;
    lsc_pkg::t_pix      r_fwd_up;
    lsc_pkg::t_pix      r_fwd_mid;
    logic [MW-1:0]      mem_rd;
    lsc_pkg::t_pix      s1_up;
    lsc_pkg::t_pix      s1_mid;

    // stage 2: window holds the neighbourhood
    logic               r_s2_valid;
    logic               r_s2_emit;
    logic               r_s2_last;
    lsc_pkg::t_nbr_mask r_s2_mask;
    lsc_pkg::t_col      new_col;
    lsc_pkg::t_col      win [3];
    lsc_pkg::t_pix      sharp_pix;

    // output register
    logic               r_out_valid;
    lsc_pkg::t_pix      r_out_pix;
    logic               r_out_last;

    // size register write, clamped to 3..MAX_SIZE once here
    always_comb begin
        cfg_ext = 32'(i_cfg_wdata);
        if (cfg_ext < 32'd3) begin
            n_side = SIDE_MIN;
        end else if (cfg_ext > 32'(MAX_SIZE)) begin
            n_side = SIDE_MAX;
        end else begin
            n_side = NW'(cfg_ext);
        end
    end

    // stall propagates back from the output register; non-emitting
    // requests leave stage 2 without needing it
    assign out_free   = !r_out_valid || i_m_tready;
    assign s2_go      = r_s2_valid && (!r_s2_emit || out_free);
    assign s2_rdy     = !r_s2_valid || s2_go;
    assign s1_go      = r_s1_valid && s2_rdy;
    assign s1_rdy     = !r_s1_valid || s1_go;
    assign accept     = i_s_tvalid && s1_rdy;
    assign o_s_tready = s1_rdy;

    // output is for the position one row and one pixel back;
    // masks hold only where a result is emitted
    always_comb begin
        col_ext  = NW'(r_col);
        col_inc  = col_ext + NW'(1);
        row_prev = (r_col == '0) ? r_row - NW'(1) : r_row;
        in_emit  = (r_row >= NW'(2)) || ((r_row == NW'(1)) && (r_col != '0));
        in_last  = (r_col == '0) && (r_row == r_side + NW'(1));
        in_mask.up    = row_prev >= NW'(2);
        in_mask.down  = row_prev < r_side;
        in_mask.left  = r_col != AW'(1);
        in_mask.right = r_col != '0;
        // drain inside the image and pixels past its end both count as zero
        in_pix = ((i_s_tuser == lsc_pkg::OP_PIXEL) && (r_row < r_side)) ? i_s_tdata : '0;
        if (in_last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= r_side) begin
            n_col = '0;
            n_row = r_row + NW'(1);
        end else begin
            n_col = AW'(col_inc);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= NW'(RESET_SIDE);
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cfg_we) begin
            // a size write restarts the frame
            r_side <= n_side;
            r_col  <= '0;
            r_row  <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores, upper in the high byte; read at accept, written when stage 1 moves on
    lsc_line_mem #(
        .DEPTH (MAX_SIZE),
        .WIDTH (MW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (mem_rd),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({s1_mid, r_s1_pix})
    );

    // a read that meets the write of the same column takes the new data
    assign s1_up  = r_fwd ? r_fwd_up  : mem_rd[MW-1:lsc_pkg::PIX_W];
    assign s1_mid = r_fwd ? r_fwd_mid : mem_rd[lsc_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_valid <= accept;
            end
            if (s2_rdy) begin
                r_s2_valid <= s1_go;
            end
            if (s2_go && r_s2_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= r_col;
            r_s1_pix  <= in_pix;
            r_s1_emit <= in_emit;
            r_s1_last <= in_last;
            r_s1_mask <= in_mask;
            r_fwd     <= s1_go && (r_s1_addr == r_col);
            r_fwd_up  <= s1_mid;
            r_fwd_mid <= r_s1_pix;
        end
        if (s1_go) begin
            r_s2_emit <= r_s1_emit;
            r_s2_last <= r_s1_last;
            r_s2_mask <= r_s1_mask;
        end
        if (s2_go && r_s2_emit) begin
            r_out_pix  <= sharp_pix;
            r_out_last <= r_s2_last;
        end
    end

    // window: three column cells, newest on the right, shifting left
    assign new_col.top = s1_up;
    assign new_col.mid = s1_mid;
    assign new_col.bot = r_s1_pix;

    for (genvar k = 0; k < 3; k++) begin : g_cell
        if (k == 2) begin : g_head
            lsc_col_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (s1_go),
                .i_col   (new_col),
                .o_col   (win[k])
            );
        end else begin : g_body
            lsc_col_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (s1_go),
                .i_col   (win[k+1]),
                .o_col   (win[k])
            );
        end
    end

    lsc_sharpen u_sharpen (
        .i_left   (win[0]),
        .i_centre (win[1]),
        .i_right  (win[2]),
        .i_mask   (r_s2_mask),
        .o_pix    (sharp_pix)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/lsc_checker.sv
`default_nettype none

`include "laplacian_subtract_clamp_3x3_core_defines.svh"

module lsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tlast
);

    // a held result keeps its payload
    `LSC_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "output changed while stalled")

    // reset empties the output register
    `LSC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

    // with the output register empty nothing can block the input
    `LSC_ASSERT(a_ready_free, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready, "input blocked with empty output")

endmodule

bind laplacian_subtract_clamp_3x3_core lsc_checker u_lsc_checker (.*);

`default_nettype wire

FILE: test/laplacian_subtract_clamp_3x3_core_test.sv
module laplacian_subtract_clamp_3x3_core_test;

    localparam int SIDE_MAX   = 1024;
    localparam int CFG_W      = lsc_pkg::CFG_W;
    localparam int LONG_HOLD  = 300;   // receiver hold-off used to back up the pipe
    localparam int TAIL_WAIT  = 8;     // lets the pipe empty after the last owed pixel, with margin
    localparam int QUIET_MAX  = 3000;  // cycles with no handshake before giving up
    localparam int RAND_ITEMS = 150;

    // one request on the input stream
    typedef struct packed {
        logic          op;
        lsc_pkg::t_pix pix;
    } t_pix_req;

    // one sharpened output pixel
    typedef struct packed {
        lsc_pkg::t_pix pix;
        logic          last;
    } t_sharp;

    // clock, reset and the block's ports
    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;    // [7:0] pixel_in
    logic                 s_tuser   = 1'b0;  // [0] op
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;           // [7:0] pixel_out
    logic                 m_tlast;           // frame_last
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // requests waiting for the driver, and sharpened pixels still owed by the block
    t_pix_req req_q[$];
    t_sharp   sharp_q[$];

    // predictor copy of the block state
    lsc_pkg::t_pix top_line [SIDE_MAX];
    lsc_pkg::t_pix mid_line [SIDE_MAX];
    lsc_pkg::t_col win_left, win_centre, win_right;
    int unsigned   size_reg = 256;
    int unsigned   col_cnt  = 0;
    int unsigned   row_cnt  = 0;

    // stimulus control, written by the sequence at falling edges only (hold_ack by the receiver)
    bit src_calm = 1'b0;
    bit snk_calm = 1'b0;
    int hold_req = 0;
    int hold_ack = 0;

    int unsigned src_gap = 0;
    int unsigned snk_gap = 0;
    int unsigned quiet   = 0;
    int unsigned mismatches = 0;
    int unsigned items_queued = 0;

    laplacian_subtract_clamp_3x3_core #(
        .MAX_SIZE(SIDE_MAX)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // effective side: sizes below 3 act as 3, above the store depth as the depth
    function automatic int unsigned side_len();
        if (size_reg < 3) return 3;
        if (size_reg > SIDE_MAX) return SIDE_MAX;
        return size_reg;
    endfunction

    // advance the predictor by one accepted request; owes a pixel once the
    // window holds a full neighbourhood (one row plus one pixel behind)
    function automatic void sharpen_step(input logic op, input lsc_pkg::t_pix pix);
        int unsigned   n, r, c, ci, rp, cp, cr;
        int            centre, nsum, val;
        lsc_pkg::t_pix v;
        logic          last;
        t_sharp        res;
        n    = side_len();
        r    = row_cnt;
        c    = col_cnt;
        ci   = (c < SIDE_MAX) ? c : SIDE_MAX - 1;
        last = 1'b0;
        // drain inside the image reads as zero, pixels past the image are ignored
        v = (op == lsc_pkg::OP_PIXEL && r < n) ? pix : '0;

        win_left       = win_centre;
        win_centre     = win_right;
        win_right.top  = top_line[ci];
        win_right.mid  = mid_line[ci];
        win_right.bot  = v;
        top_line[ci]   = mid_line[ci];
        mid_line[ci]   = v;

        if (r * n + c >= n + 1) begin
            rp     = (c == 0) ? r - 1 : r;
            cp     = (c == 0) ? n - 1 : c - 1;
            cr     = rp - 1;
            centre = win_centre.mid;
            nsum   = 0;
            // neighbours outside the image count as zero
            if (cr >= 1)         nsum += win_centre.top;
            if (cr + 1 <= n - 1) nsum += win_centre.bot;
            if (cp >= 1)         nsum += win_left.mid;
            if (cp + 1 <= n - 1) nsum += win_right.mid;
            // centre minus (4*centre - sum)
            val = nsum - 3 * centre;
            if (val < 0)   val = 0;
            if (val > 255) val = 255;
            last     = (cr == n - 1) && (cp == n - 1);
            res.pix  = lsc_pkg::t_pix'(val);
            res.last = last;
            sharp_q.push_back(res);
        end

        // frame end wraps the counters, otherwise raster advance
        if (last) begin
            row_cnt = 0;
            col_cnt = 0;
        end else begin
            c++;
            if (c >= n) begin
                c = 0;
                r++;
            end
            col_cnt = c;
            row_cnt = r;
        end
    endfunction

    // idle gap: mostly none, some short, a few long
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void report_miss(input string what, input t_sharp want,
                                        input lsc_pkg::t_pix got_pix, input logic got_last);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected pix %0d last %0b, got pix %0d last %0b",
                     what, want.pix, want.last, got_pix, got_last);
    endfunction

    // driver: presents queued requests, predicts each one as it is accepted
    always @(posedge i_clk) begin : driver
        t_pix_req req;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            // a size write restarts the frame
            if (cfg_we) begin
                size_reg = 32'(cfg_wdata);
                col_cnt  = 0;
                row_cnt  = 0;
            end
            if (s_tvalid && s_tready)
                sharpen_step(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    s_tvalid <= 1'b0;
                    src_gap  <= src_gap - 1;
                end else if (req_q.size() != 0) begin
                    req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.pix;
                    s_tuser  <= req.op;
                    src_gap  <= pick_gap(src_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each output against the oldest owed pixel, drives ready
    always @(posedge i_clk) begin : receiver
        t_sharp want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            snk_gap  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sharp_q.size() == 0) begin
                    want = '0;
                    report_miss("result with none owed", want, m_tdata, m_tlast);
                end else begin
                    want = sharp_q.pop_front();
                    if (m_tdata !== want.pix || m_tlast !== want.last)
                        report_miss("wrong result", want, m_tdata, m_tlast);
                end
            end
            if (snk_gap != 0) begin
                m_tready <= 1'b0;
                snk_gap  <= snk_gap - 1;
            end else if (hold_ack != hold_req) begin
                // long hold-off so the block fills and stalls its input
                m_tready <= 1'b0;
                snk_gap  <= LONG_HOLD;
                hold_ack <= hold_ack + 1;
            end else begin
                m_tready <= 1'b1;
                if (!snk_calm && $urandom_range(0, 3) == 0)
                    snk_gap <= pick_gap(1'b0);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic void push_item(input logic op, input lsc_pkg::t_pix pix);
        t_pix_req req;
        req.op  = op;
        req.pix = pix;
        req_q.push_back(req);
        items_queued++;
    endfunction

    // pixel content: uniform, extremes only, or a smooth patch of nearby values
    function automatic lsc_pkg::t_pix next_pixel(input int unsigned kind,
                                                 input int unsigned base);
        case (kind)
            0: return lsc_pkg::t_pix'($urandom_range(0, 255));
            1: return ($urandom_range(0, 1) != 0) ? lsc_pkg::PIX_MAX : '0;
            default: return lsc_pkg::t_pix'(base + $urandom_range(0, 15));
        endcase
    endfunction

    // one frame of n*n pixels and n+1 drains; style 1 flips ops at random,
    // style 2 cuts the frame short so the next one starts out of step
    function automatic void push_frame(input int unsigned n, input int unsigned style);
        int unsigned total, k, kind, base;
        logic        op;
        kind  = $urandom_range(0, 2);
        base  = $urandom_range(0, 240);
        total = n * n + n + 1;
        if (style == 2) total = $urandom_range(1, total - 1);
        for (k = 0; k < total; k++) begin
            op = (k < n * n) ? lsc_pkg::OP_PIXEL : lsc_pkg::OP_DRAIN;
            if (style == 1 && $urandom_range(0, 3) == 0)
                op = (op == lsc_pkg::OP_PIXEL) ? lsc_pkg::OP_DRAIN : lsc_pkg::OP_PIXEL;
            push_item(op, next_pixel(kind, base));
        end
    endfunction

    // wait until every request went in and every owed pixel came out,
    // then let the pipe empty of requests that owe nothing
    task automatic settle();
        do @(negedge i_clk);
        while (req_q.size() != 0 || s_tvalid || sharp_q.size() != 0);
        repeat (TAIL_WAIT) @(negedge i_clk);
    endtask

    task automatic write_size(input int unsigned value);
        settle();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // stimulus sequence
    initial begin : sequencer
        int unsigned k, sz, roll, frames, rand_start;
        foreach (top_line[i]) begin
            top_line[i] = '0;
            mid_line[i] = '0;
        end
        win_left   = '0;
        win_centre = '0;
        win_right  = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset size of 256: a bit more than a row plus one pixel
        for (k = 0; k < 260; k++)
            push_item(lsc_pkg::OP_PIXEL, lsc_pkg::t_pix'($urandom_range(0, 255)));

        // checkerboard of extremes drives both clamps
        write_size(3);
        for (k = 0; k < 9; k++)
            push_item(lsc_pkg::OP_PIXEL, (k % 2 == 0) ? lsc_pkg::PIX_MAX : '0);
        for (k = 0; k < 4; k++)
            push_item(lsc_pkg::OP_DRAIN, lsc_pkg::PIX_MAX);
        // drain in the middle of the image, pixels past the image end
        for (k = 0; k < 9; k++)
            push_item((k == 4) ? lsc_pkg::OP_DRAIN : lsc_pkg::OP_PIXEL, lsc_pkg::PIX_MAX);
        for (k = 0; k < 4; k++)
            push_item(lsc_pkg::OP_PIXEL, lsc_pkg::PIX_MAX);

        // sizes below the minimum act as 3
        for (sz = 0; sz < 3; sz++) begin
            write_size(sz);
            push_frame(3, 0);
        end

        // full pipe: receiver holds off while the sender keeps offering
        write_size(8);
        src_calm = 1'b1;
        snk_calm = 1'b1;
        hold_req++;
        for (k = 0; k < 2; k++) push_frame(8, 0);

        // random frames at small sizes, mostly clean, some noisy or cut short
        rand_start = items_queued;
        while (items_queued - rand_start < RAND_ITEMS) begin
            sz = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 16);
            write_size(sz);
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            frames   = $urandom_range(1, 3);
            for (k = 0; k < frames; k++) begin
                roll = $urandom_range(0, 99);
                push_frame((sz < 3) ? 3 : sz, (roll < 75) ? 0 : (roll < 88) ? 1 : 2);
            end
        end

        // all-ones register clamps to the store depth: a row plus a few pixels
        src_calm = 1'b0;
        snk_calm = 1'b0;
        write_size(11'h7FF);
        for (k = 0; k < 1030; k++)
            push_item(($urandom_range(0, 15) == 0) ? lsc_pkg::OP_DRAIN : lsc_pkg::OP_PIXEL,
                      next_pixel(k % 3, 60));

        settle();
        if (mismatches == 0 && sharp_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lsc_pkg.sv
rtl/lsc_line_mem.sv
rtl/lsc_col_cell.sv
rtl/lsc_sharpen.sv
rtl/laplacian_subtract_clamp_3x3_core.sv
rtl/lsc_checker.sv
test/laplacian_subtract_clamp_3x3_core_test.sv
